### rtl/core/fbpc_pkg.sv
// Shared types and constants for the frustum cull block.
`default_nettype none
package fbpc_pkg;
  localparam int NumPlaneRegs = 6;
  localparam int CfgIdxW = 3;
  localparam int CoordW = 32;
  localparam int DistW = 52;

  localparam logic OP_CHUNK = 1'b0;
  localparam logic OP_POINT = 1'b1;

  // Classified word handed from front to back.
  typedef struct packed {
    logic              is_point;
    logic [CoordW-1:0] x0;
    logic [CoordW-1:0] y0;
    logic [CoordW-1:0] z0;
  } fbpc_item_t;

  typedef struct packed {
    logic signed [13:0] nx;
    logic signed [13:0] ny;
    logic signed [13:0] nz;
    logic signed [21:0] d;
  } fbpc_plane_t;

  function automatic fbpc_plane_t fbpc_unpack(input logic [63:0] r);
    fbpc_plane_t p;
    p.nx = r[13:0];
    p.ny = r[27:14];
    p.nz = r[41:28];
    p.d  = r[63:42];
    return p;
  endfunction
endpackage
`default_nettype wire

### rtl/core/frustum_box_point_cull.sv
// Top level: plane registers, front queue and back distance pipeline.
`default_nettype none
// out_valid rises after a word passes the queue, the product stage and the output reg.
// Throughput: one word per cycle if not stalled; six planes evaluated in parallel per stage.
// A two-entry queue and the output register let each side stall on its own.
// Box test uses the corner of maximal distance per plane (per-axis max).
// Reset (rst_n low, synchronous) empties queue and pipeline, zeroes planes.
module frustum_box_point_cull import fbpc_pkg::*; #(
  parameter int CHUNK_WIDTH  = 32,
  parameter int CHUNK_HEIGHT = 256,
  parameter int PLANE_COUNT  = 6
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [63:0]       cfg_data,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              in_op,
  input  wire logic signed [15:0] in_chunk_x,
  input  wire logic signed [15:0] in_chunk_z,
  input  wire logic signed [20:0] in_point_x,
  input  wire logic signed [20:0] in_point_y,
  input  wire logic signed [20:0] in_point_z,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   out_visible
);
  logic [63:0] plane_r [NumPlaneRegs];
  logic        q_valid, q_take;
  fbpc_item_t  q_item;

  // Writes beyond the last plane are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NumPlaneRegs; i++) plane_r[i] <= '0;
    end else if (cfg_we && (32'(cfg_index) < NumPlaneRegs)) begin
      plane_r[cfg_index] <= cfg_data;
    end
  end

  fbpc_front #(.CHUNK_WIDTH(CHUNK_WIDTH)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_op, .in_chunk_x, .in_chunk_z,
    .in_point_x, .in_point_y, .in_point_z, .q_valid, .q_take, .q_item
  );

  fbpc_back #(
    .CHUNK_WIDTH(CHUNK_WIDTH), .CHUNK_HEIGHT(CHUNK_HEIGHT), .PLANE_COUNT(PLANE_COUNT)
  ) u_back (
    .clk, .rst_n, .planes(plane_r), .q_valid, .q_take, .q_item,
    .out_valid, .out_stall, .out_visible
  );
endmodule
`default_nettype wire

### rtl/core/fbpc_front.sv
// Front end: accepts words, forms base coordinates, holds a two-entry queue.
`default_nettype none
module fbpc_front import fbpc_pkg::*; #(
  parameter int CHUNK_WIDTH = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              in_op,
  input  wire logic signed [15:0] in_chunk_x,
  input  wire logic signed [15:0] in_chunk_z,
  input  wire logic signed [20:0] in_point_x,
  input  wire logic signed [20:0] in_point_y,
  input  wire logic signed [20:0] in_point_z,
  output logic                   q_valid,
  input  wire logic              q_take,
  output fbpc_item_t             q_item
);
  fbpc_item_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  fbpc_item_t cls;
  logic       push, pop;

  always_comb begin
    cls.is_point = (in_op == OP_POINT);
    if (in_op == OP_POINT) begin
      cls.x0 = CoordW'(in_point_x);
      cls.y0 = CoordW'(in_point_y);
      cls.z0 = CoordW'(in_point_z);
    end else begin
      cls.x0 = CoordW'(signed'(in_chunk_x) * signed'(CoordW'(CHUNK_WIDTH)));
      cls.y0 = '0;
      cls.z0 = CoordW'(signed'(in_chunk_z) * signed'(CoordW'(CHUNK_WIDTH)));
    end
  end

  assign in_stall = (cnt_r == 2'd2);
  assign push = in_valid && !in_stall;
  assign q_valid = (cnt_r != 2'd0);
  assign pop = q_valid && q_take;
  assign q_item = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= cls;
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (rst_n) begin
      assert (cnt_r <= 2'd2) else $error("queue overflow");
    end
  end
  property p_no_push_full;
    @(posedge clk) disable iff (!rst_n) (cnt_r == 2'd2) |-> !push;
  endproperty
  a_no_push_full: assert property (p_no_push_full) else $error("push into full queue");
  property p_cnt_up;
    @(posedge clk) disable iff (!rst_n) (push && !pop) |=> (cnt_r == $past(cnt_r) + 2'd1);
  endproperty
  a_cnt_up: assert property (p_cnt_up) else $error("count slip");
  property p_ptr;
    @(posedge clk) disable iff (!rst_n) (cnt_r == 2'd0) |-> (wp_r == rp_r);
  endproperty
  a_ptr: assert property (p_ptr) else $error("pointer mismatch");
endmodule
`default_nettype wire

### rtl/core/fbpc_back.sv
// Back end: plane products in one register stage, then output register.
`default_nettype none
module fbpc_back import fbpc_pkg::*; #(
  parameter int CHUNK_WIDTH  = 32,
  parameter int CHUNK_HEIGHT = 256,
  parameter int PLANE_COUNT  = 6
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [63:0]       planes [NumPlaneRegs],
  input  wire logic              q_valid,
  output logic                   q_take,
  input  wire fbpc_item_t        q_item,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   out_visible
);
  localparam int NAct = (PLANE_COUNT < NumPlaneRegs) ? PLANE_COUNT : NumPlaneRegs;

  // Stage 1: per-plane per-axis products for both extremes of each axis.
  logic signed [DistW-1:0] px_lo_r [NumPlaneRegs], px_hi_r [NumPlaneRegs];
  logic signed [DistW-1:0] py_lo_r [NumPlaneRegs], py_hi_r [NumPlaneRegs];
  logic signed [DistW-1:0] pz_lo_r [NumPlaneRegs], pz_hi_r [NumPlaneRegs];
  logic signed [DistW-1:0] pd_r    [NumPlaneRegs];
  logic s1_v_r;
  // Stage 2 is the output register.
  logic vis_r, ov_r;
  logic adv, s1_take, vis_nxt;

  assign adv = !ov_r || !out_stall;
  assign s1_take = adv || !s1_v_r;
  assign q_take = s1_take;

  always_ff @(posedge clk) begin
    if (s1_take && q_valid) begin
      for (int p = 0; p < NumPlaneRegs; p++) begin
        fbpc_plane_t pl;
        logic signed [CoordW-1:0] xh, yh, zh;
        pl = fbpc_unpack(planes[p]);
        xh = signed'(q_item.x0) + (q_item.is_point ? 0 : CHUNK_WIDTH);
        yh = signed'(q_item.y0) + (q_item.is_point ? 0 : CHUNK_HEIGHT);
        zh = signed'(q_item.z0) + (q_item.is_point ? 0 : CHUNK_WIDTH);
        px_lo_r[p] <= DistW'(pl.nx * signed'(q_item.x0));
        px_hi_r[p] <= DistW'(pl.nx * xh);
        py_lo_r[p] <= DistW'(pl.ny * signed'(q_item.y0));
        py_hi_r[p] <= DistW'(pl.ny * yh);
        pz_lo_r[p] <= DistW'(pl.nz * signed'(q_item.z0));
        pz_hi_r[p] <= DistW'(pl.nz * zh);
        pd_r[p]    <= DistW'(pl.d) <<< 11;
      end
    end
    if (!rst_n) s1_v_r <= 1'b0;
    else if (s1_take) s1_v_r <= q_valid;
  end

  // Box culled by a plane iff its most positive corner is still negative.
  always_comb begin
    vis_nxt = 1'b1;
    for (int p = 0; p < NAct; p++) begin
      logic signed [DistW-1:0] mx, my, mz, plane_dist;
      mx = (px_hi_r[p] > px_lo_r[p]) ? px_hi_r[p] : px_lo_r[p];
      my = (py_hi_r[p] > py_lo_r[p]) ? py_hi_r[p] : py_lo_r[p];
      mz = (pz_hi_r[p] > pz_lo_r[p]) ? pz_hi_r[p] : pz_lo_r[p];
      plane_dist = mx + my + mz + pd_r[p];
      if (plane_dist < 0) vis_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_v_r) vis_r <= vis_nxt;
    if (!rst_n) ov_r <= 1'b0;
    else if (adv) ov_r <= s1_v_r;
  end

  assign out_valid = ov_r;
  assign out_visible = vis_r;

  property p_hold;
    @(posedge clk) disable iff (!rst_n) (ov_r && out_stall) |=> ov_r;
  endproperty
  a_hold: assert property (p_hold) else $error("result dropped");
  property p_flow;
    @(posedge clk) disable iff (!rst_n) (s1_v_r && adv) |=> ov_r;
  endproperty
  a_flow: assert property (p_flow) else $error("stage lost word");
  property p_keep;
    @(posedge clk) disable iff (!rst_n) (s1_v_r && !adv) |=> s1_v_r;
  endproperty
  a_keep: assert property (p_keep) else $error("stage 1 overwritten");
endmodule
`default_nettype wire

### test/frustum_box_point_cull_tb.sv
// Testbench for frustum_box_point_cull: random and directed cull words checked against a predictor.
`default_nettype none
module frustum_box_point_cull_tb;
  import fbpc_pkg::*;

  localparam int CW = 32;
  localparam int CH = 256;
  localparam int WATCHDOG_LIMIT = 20000;

  // one pending input word
  typedef struct {
    logic        op;
    logic [15:0] cx;
    logic [15:0] cz;
    logic [20:0] px;
    logic [20:0] py;
    logic [20:0] pz;
    bit          hold_drain; // sender waits for all results before this word
  } cull_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_op = 1'b0;
  logic signed [15:0] in_chunk_x = '0;
  logic signed [15:0] in_chunk_z = '0;
  logic signed [20:0] in_point_x = '0;
  logic signed [20:0] in_point_y = '0;
  logic signed [20:0] in_point_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_visible;

  frustum_box_point_cull dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_op(in_op),
    .in_chunk_x(in_chunk_x), .in_chunk_z(in_chunk_z),
    .in_point_x(in_point_x), .in_point_y(in_point_y), .in_point_z(in_point_z),
    .out_valid(out_valid), .out_stall(out_stall), .out_visible(out_visible)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // predictor copy of the plane registers
  logic [63:0] planes [NumPlaneRegs];
  cull_word_t pending_words[$];
  bit visible_expected[$];
  int mismatches = 0;
  int accepted_in = 0;
  int results_seen = 0;
  int n_chunk = 0, n_point = 0, n_hidden = 0;
  int idle_cycles = 0;
  bit drv_enable = 1'b0;
  int long_hold = 0;  // request for a long receiver hold-off

  // exact signed distance at scale 4096; negative means outside the plane
  function automatic bit outside_plane(input logic [63:0] r, input longint x,
                                       input longint y, input longint z);
    longint nx, ny, nz, d;
    nx = longint'($signed(r[13:0]));
    ny = longint'($signed(r[27:14]));
    nz = longint'($signed(r[41:28]));
    d  = longint'($signed(r[63:42]));
    return (nx * x + ny * y + nz * z + d * 2048) < 0;
  endfunction

  function automatic bit predict_visible(input cull_word_t w);
    longint x0, z0, x, y, z;
    bit vis, all_out;
    vis = 1'b1;
    if (w.op == OP_CHUNK) begin
      x0 = longint'($signed(w.cx)) * CW;
      z0 = longint'($signed(w.cz)) * CW;
      for (int p = 0; p < NumPlaneRegs; p++) begin
        all_out = 1'b1;
        for (int c = 0; c < 8; c++) begin
          x = x0 + ((c & 1) ? CW : 0);
          y = (c & 2) ? CH : 0;
          z = z0 + ((c & 4) ? CW : 0);
          if (!outside_plane(planes[p], x, y, z)) all_out = 1'b0;
        end
        if (all_out) vis = 1'b0;
      end
    end else begin
      for (int p = 0; p < NumPlaneRegs; p++)
        if (outside_plane(planes[p], longint'($signed(w.px)), longint'($signed(w.py)),
                          longint'($signed(w.pz)))) vis = 1'b0;
    end
    return vis;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // driver: offers words from pending_words, random gaps, one NBA per step
  int drv_gap = 0;
  bit drv_wait_drain = 1'b0;
  always @(posedge clk) begin
    if (in_valid && !in_stall) begin
      accepted_in <= accepted_in + 1;
    end
    if (in_valid && in_stall) begin
      // word held until accepted
    end else if (!drv_enable || pending_words.size() == 0) begin
      in_valid <= 1'b0;
    end else if (drv_gap > 0) begin
      drv_gap <= drv_gap - 1;
      in_valid <= 1'b0;
    end else if (pending_words[0].hold_drain &&
                 (visible_expected.size() != 0 || in_valid)) begin
      in_valid <= 1'b0;
    end else begin
      cull_word_t w;
      w = pending_words.pop_front();
      visible_expected.insert(visible_expected.size(), predict_visible(w));
      if (w.op == OP_CHUNK) n_chunk++; else n_point++;
      in_valid <= 1'b1;
      in_op <= w.op;
      in_chunk_x <= w.cx;
      in_chunk_z <= w.cz;
      in_point_x <= w.px;
      in_point_y <= w.py;
      in_point_z <= w.pz;
      drv_gap <= gap_len();
    end
  end

  // monitor and receiver stall
  int rx_hold = 0;
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen <= results_seen + 1;
      if (visible_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word: visible=%0b", out_visible);
      end else begin
        bit e;
        e = visible_expected.pop_front();
        if (!e) n_hidden++;
        if (out_visible !== e) begin
          mismatches++;
          if (mismatches <= 10)
            $display("visible mismatch at result %0d: expected %0b got %0b",
                     results_seen, e, out_visible);
        end
      end
    end
    if (long_hold > 0) begin
      rx_hold <= long_hold;
      long_hold <= 0;
      out_stall <= 1'b1;
    end else if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      out_stall <= 1'b1;
    end else begin
      rx_hold <= gap_len();
      out_stall <= ($urandom_range(0, 2) == 0) ? 1'b1 : 1'b0;
    end
  end

  // watchdog: cycles with no handshake on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired: %0d words still expected", visible_expected.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic write_plane(input int idx, input logic [63:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CfgIdxW'(idx);
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx < NumPlaneRegs) planes[idx] = val;
  endtask

  function automatic logic [63:0] pack_plane(input logic [13:0] nx, input logic [13:0] ny,
                                             input logic [13:0] nz, input logic [21:0] d);
    return {d, nz, ny, nx};
  endfunction

  task automatic add_chunk(input logic [15:0] cx, input logic [15:0] cz, input bit hd = 0);
    cull_word_t w;
    w.op = OP_CHUNK; w.cx = cx; w.cz = cz;
    w.px = 21'($urandom); w.py = 21'($urandom); w.pz = 21'($urandom);
    w.hold_drain = hd;
    pending_words.insert(pending_words.size(), w);
  endtask

  task automatic add_point(input logic [20:0] px, input logic [20:0] py,
                           input logic [20:0] pz, input bit hd = 0);
    cull_word_t w;
    w.op = OP_POINT; w.px = px; w.py = py; w.pz = pz;
    w.cx = 16'($urandom); w.cz = 16'($urandom);
    w.hold_drain = hd;
    pending_words.insert(pending_words.size(), w);
  endtask

  // feed and wait until every word has its result
  task automatic run_phase();
    drv_enable = 1'b1;
    wait (pending_words.size() == 0);
    @(posedge clk);
    while (visible_expected.size() != 0 || in_valid) @(posedge clk);
    drv_enable = 1'b0;
    repeat (6) @(posedge clk);
  endtask

  // random small-world plane: random normals; offsets small in mode 0, full range otherwise
  function automatic logic [63:0] rand_plane(input int mode);
    logic [13:0] nx, ny, nz;
    logic [21:0] d;
    nx = 14'($urandom); ny = 14'($urandom); nz = 14'($urandom);
    d = (mode == 0) ? 22'($signed($urandom_range(0, 4000)) - 2000) : 22'($urandom);
    return pack_plane(nx, ny, nz, d);
  endfunction

  // mostly small coordinates so both outcomes occur; some full range
  function automatic logic [20:0] rand_coord();
    if ($urandom_range(0, 9) < 8) return 21'($signed($urandom_range(0, 2000)) - 1000);
    return 21'($urandom);
  endfunction

  function automatic logic [15:0] rand_chunk();
    if ($urandom_range(0, 9) < 8) return 16'($signed($urandom_range(0, 60)) - 30);
    return 16'($urandom);
  endfunction

  task automatic add_random(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 1)) add_chunk(rand_chunk(), rand_chunk());
      else add_point(rand_coord(), rand_coord(), rand_coord());
    end
  endtask

  initial begin
    for (int i = 0; i < NumPlaneRegs; i++) planes[i] = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // after reset all planes are zero: everything touches, so all visible
    add_chunk(16'h8000, 16'h7fff);
    add_chunk(16'h7fff, 16'h8000);
    add_point(21'h100000, 21'h0fffff, 21'h100000);
    add_point(21'h0fffff, 21'h100000, 21'h0fffff);
    run_phase();

    // directed: plane x >= 0 on slot 0; others keep zero so they never cull
    write_plane(0, pack_plane(14'sd4096, 14'sd0, 14'sd0, 22'sd0));
    write_plane(6, '1);  // index out of range is ignored
    write_plane(7, '1);
    add_point(21'd0, 21'd5, 21'd5);          // on the plane: visible
    add_point(-21'sd1, 21'd0, 21'd0);        // just outside
    add_point(21'h0fffff, 21'h100000, 21'h100000);
    add_point(21'h100000, 21'h0fffff, 21'h0fffff);
    add_chunk(-16'sd1, 16'd0);               // right face touches x = 0
    add_chunk(-16'sd2, 16'd0);               // fully outside
    add_chunk(16'h8000, 16'h8000);
    add_chunk(16'h7fff, 16'h7fff);
    // plane y <= 100 with half-unit offset, on slot 5: box straddles, point above culled
    write_plane(5, pack_plane(14'sd0, -14'sd4096, 14'sd0, 22'sd201));
    add_point(21'd0, 21'd100, 21'd0);
    add_point(21'd0, 21'd101, 21'd0);
    add_chunk(16'd3, -16'sd3);
    run_phase();

    // extreme planes: most negative / most positive fields
    write_plane(1, pack_plane(14'h2000, 14'h2000, 14'h2000, 22'h200000));
    write_plane(2, pack_plane(14'h1fff, 14'h1fff, 14'h1fff, 22'h1fffff));
    write_plane(3, '1);
    write_plane(4, '0);
    add_random(20);
    run_phase();

    // random phases with new plane sets; each drains once, one has a long receiver hold
    for (int ph = 0; ph < 6; ph++) begin
      for (int i = 0; i < NumPlaneRegs; i++)
        if ($urandom_range(0, 3) != 0) write_plane(i, rand_plane(ph % 3 == 2));
        else write_plane(i, '0);
      if (ph == 1) long_hold = 150;
      add_random(45);
      add_point(rand_coord(), rand_coord(), rand_coord(), 1'b1); // sender drains first
      add_random(45);
      run_phase();
    end

    // back to reset values to close
    for (int i = 0; i < NumPlaneRegs; i++) write_plane(i, '0);
    add_random(20);
    run_phase();

    repeat (10) @(posedge clk);
    $display("covered %0d chunk and %0d point words, %0d culled, %0d accepted, %0d results",
             n_chunk, n_point, n_hidden, accepted_in, results_seen);
    if (mismatches == 0 && visible_expected.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("mismatches: %0d, left over: %0d", mismatches, visible_expected.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
`default_nettype wire

### files.f
rtl/core/fbpc_pkg.sv
rtl/core/fbpc_front.sv
rtl/core/fbpc_back.sv
rtl/core/frustum_box_point_cull.sv
test/frustum_box_point_cull_tb.sv
